/* sv/mu8dh_pkg.sv */
// Shared types and constants for the modified UTF-8 decoder with string hash.
package mu8dh_pkg;

    // Hash multiplier and count ceiling
    localparam logic [63:0] HASH_MULT = 64'd37;
    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    // Lead byte form bits and string terminator byte
    localparam int unsigned LEAD_MULTI_BIT = 7;
    localparam int unsigned LEAD_THREE_BIT = 5;
    localparam logic [7:0]  TERM_BYTE      = 8'h00;

    // Continuation bytes still expected
    typedef enum logic [1:0] {
        PEND_NONE = 2'd0,
        PEND_ONE  = 2'd1,
        PEND_TWO  = 2'd2
    } pending_t;

endpackage

/* sv/modified_utf8_decode_hash_top.sv */
// Modified UTF-8 byte-stream decoder emitting characters and a running hash.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+------------------------------------------
//   input   | in_valid  | in_stall  | byte_in
//   output  | out_valid | out_stall | code_unit, is_end, string_hash, char_count
//
// One byte is taken per cycle while in_stall is low; a transaction passes the input
// register and then the decode/hash step into the result register.
// The hash update (shift-add by 37 plus one 64-bit add) sets the cycle time.
// Reset clears the decoder state, hash and count and empties both registers.
// A stalled result holds the input register only when that byte yields a
// result; bytes that yield none keep flowing.
module modified_utf8_decode_hash_top
    import mu8dh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  byte_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] code_unit,
    output logic        is_end,
    output logic [63:0] string_hash,
    output logic [31:0] char_count
);

    // Input register
    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;

    // Decoder state
    pending_t    pending_reg, pending_next;
    logic [15:0] partial_reg, partial_next;
    logic [63:0] hash_reg, hash_next;
    logic [31:0] count_reg, count_next;

    // Result register
    logic        out_valid_reg;
    logic [15:0] code_reg, code_next;
    logic        end_reg, end_next;
    logic [63:0] ohash_reg, ohash_next;
    logic [31:0] ocount_reg, ocount_next;

    logic        is_term;
    logic        produces;
    logic        s1_adv;
    logic        out_free;
    logic [15:0] ch;
    logic [63:0] hash_upd;
    logic [31:0] count_upd;

    // Decode of the byte held in the input register
    always_comb
    begin
        is_term      = (s1_byte_reg == TERM_BYTE);
        produces     = 1'b0;
        ch           = {8'h00, s1_byte_reg};
        pending_next = pending_reg;
        partial_next = partial_reg;
        if (is_term)
        begin
            produces     = 1'b1;
            pending_next = PEND_NONE;
            partial_next = '0;
        end
        else
        begin
            case (pending_reg)
                PEND_TWO:
                begin
                    partial_next = partial_reg | {4'h0, s1_byte_reg[5:0], 6'h00};
                    pending_next = PEND_ONE;
                end
                PEND_ONE:
                begin
                    ch           = partial_reg | {10'h000, s1_byte_reg[5:0]};
                    produces     = 1'b1;
                    pending_next = PEND_NONE;
                    partial_next = '0;
                end
                default:
                begin
                    // lead byte
                    pending_next = PEND_NONE;
                    partial_next = '0;
                    if (!s1_byte_reg[LEAD_MULTI_BIT])
                    begin
                        produces = 1'b1;
                    end
                    else if (!s1_byte_reg[LEAD_THREE_BIT])
                    begin
                        partial_next = {5'h00, s1_byte_reg[4:0], 6'h00};
                        pending_next = PEND_ONE;
                    end
                    else
                    begin
                        partial_next = {s1_byte_reg[3:0], 12'h000};
                        pending_next = PEND_TWO;
                    end
                end
            endcase
        end
    end

    // Hash and saturating count for a decoded character; 37 = 32 + 4 + 1
    assign hash_upd  = {hash_reg[58:0], 5'h00} + {hash_reg[61:0], 2'h0} + hash_reg
                       + {48'h0, ch};
    assign count_upd = (count_reg == COUNT_MAX) ? count_reg : count_reg + 32'd1;

    // Flow control
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_adv   = s1_valid_reg && (!produces || out_free);
    assign in_stall = s1_valid_reg && !s1_adv;

    // Accumulator and result values
    always_comb
    begin
        hash_next   = hash_reg;
        count_next  = count_reg;
        code_next   = ch;
        end_next    = 1'b0;
        ohash_next  = hash_upd;
        ocount_next = count_upd;
        if (is_term)
        begin
            code_next   = '0;
            end_next    = 1'b1;
            ohash_next  = hash_reg;
            ocount_next = count_reg;
            hash_next   = '0;
            count_next  = '0;
        end
        else if (produces)
        begin
            hash_next  = hash_upd;
            count_next = count_upd;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_byte_reg <= byte_in;
        end
    end

    // Decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= PEND_NONE;
            partial_reg <= '0;
            hash_reg    <= '0;
            count_reg   <= '0;
        end
        else if (s1_adv)
        begin
            pending_reg <= pending_next;
            partial_reg <= partial_next;
            hash_reg    <= hash_next;
            count_reg   <= count_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_adv && produces;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && produces)
        begin
            code_reg   <= code_next;
            end_reg    <= end_next;
            ohash_reg  <= ohash_next;
            ocount_reg <= ocount_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign code_unit   = code_reg;
    assign is_end      = end_reg;
    assign string_hash = ohash_reg;
    assign char_count  = ocount_reg;

endmodule
